>>> hw/rtl/ddo_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Differential drive odometry package
// Shared types, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CordicStepsDef = 24;
  localparam int unsigned PosFracBitsDef = 16;
  localparam logic [15:0] WheelBaseReset = 16'd500;
  localparam logic signed [35:0] Q30One = 36'sd1073741824;
  localparam logic signed [35:0] GainQ30 = 36'sd652032874;
  localparam logic [46:0] VelMax = {47{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SQR,
    ST_SQRT,
    ST_VEC,
    ST_MID,
    ST_ROT1,
    ST_STEP,
    ST_HALF,
    ST_ROT2,
    ST_DIV1,
    ST_DIV2,
    ST_OUT
  } ddo_state_e;

  typedef struct packed {
    logic load;
    logic delta;
    logic sqr;
    logic sqrt_init;
    logic sqrt_step;
    logic vec_init;
    logic vec_step;
    logic mid;
    logic rot_step;
    logic pos_step;
    logic half;
    logic div1_init;
    logic div2_init;
    logic div_step;
    logic out_load;
  } ddo_cmd_t;

  typedef struct packed {
    logic started;
    logic saturate;
    logic sqrt_last;
    logic cordic_last;
    logic div_last;
  } ddo_status_t;

  function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
    logic signed [35:0] v;
    unique case (i)
      5'd0: v = 36'sh020000000;  5'd1: v = 36'sh012E4051E;
      5'd2: v = 36'sh009FB385B;  5'd3: v = 36'sh0051111D4;
      5'd4: v = 36'sh0028B0D43;  5'd5: v = 36'sh00145D7E1;
      5'd6: v = 36'sh000A2F61E;  5'd7: v = 36'sh000517C55;
      5'd8: v = 36'sh00028BE53;  5'd9: v = 36'sh000145F2F;
      5'd10: v = 36'sh0000A2F98; 5'd11: v = 36'sh0000517CC;
      5'd12: v = 36'sh000028BE6; 5'd13: v = 36'sh0000145F3;
      5'd14: v = 36'sh00000A2FA; 5'd15: v = 36'sh00000517D;
      5'd16: v = 36'sh0000028BE; 5'd17: v = 36'sh00000145F;
      5'd18: v = 36'sh000000A30; 5'd19: v = 36'sh000000518;
      5'd20: v = 36'sh00000028C; 5'd21: v = 36'sh000000146;
      5'd22: v = 36'sh0000000A3; 5'd23: v = 36'sh000000051;
      5'd24: v = 36'sh000000029; 5'd25: v = 36'sh000000014;
      5'd26: v = 36'sh00000000A; 5'd27: v = 36'sh000000005;
      5'd28: v = 36'sh000000003; 5'd29: v = 36'sh000000001;
      5'd30: v = 36'sh000000001; default: v = 36'sh000000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ddo_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Odometry controller
// Sequences the datapath through delta, square root, vectoring, rotation,
// position update and division phases.
// ---------------------------------------------------------------------------
module ddo_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_fire_i,
  input  wire logic                  out_free_i,
  input  wire ddo_pkg::ddo_status_t  status_i,
  output ddo_pkg::ddo_cmd_t          cmd_o,
  output logic                       busy_o
);
  import ddo_pkg::*;

  ddo_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire_i && status_i.started) state_d = ST_DELTA;
      ST_DELTA: state_d = ST_SQR;
      ST_SQR: state_d = status_i.saturate ? ST_MID : ST_SQRT;
      ST_SQRT: if (status_i.sqrt_last) state_d = ST_VEC;
      ST_VEC: if (status_i.cordic_last) state_d = ST_MID;
      ST_MID: state_d = ST_ROT1;
      ST_ROT1: if (status_i.cordic_last) state_d = ST_STEP;
      ST_STEP: state_d = ST_HALF;
      ST_HALF: state_d = ST_ROT2;
      ST_ROT2: if (status_i.cordic_last) state_d = ST_DIV1;
      ST_DIV1: if (status_i.div_last) state_d = ST_DIV2;
      ST_DIV2: if (status_i.div_last) state_d = ST_OUT;
      ST_OUT: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = in_fire_i;
      end
      ST_DELTA: cmd_o.delta = 1'b1;
      ST_SQR: begin
        cmd_o.sqr = 1'b1;
        cmd_o.sqrt_init = 1'b1;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.vec_init = status_i.sqrt_last;
      end
      ST_VEC: cmd_o.vec_step = 1'b1;
      ST_MID: cmd_o.mid = 1'b1;
      ST_ROT1: cmd_o.rot_step = 1'b1;
      ST_STEP: cmd_o.pos_step = 1'b1;
      ST_HALF: cmd_o.half = 1'b1;
      ST_ROT2: begin
        cmd_o.rot_step = 1'b1;
        cmd_o.div1_init = status_i.cordic_last;
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div2_init = status_i.div_last;
      end
      ST_DIV2: cmd_o.div_step = 1'b1;
      ST_OUT: cmd_o.out_load = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/ddo_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Odometry datapath
// Holds the pose state and a shared CORDIC, a bit-serial square root and a
// restoring divider for the velocities.
// ---------------------------------------------------------------------------
module ddo_datapath #(
  parameter int unsigned CordicSteps = ddo_pkg::CordicStepsDef,
  parameter int unsigned PosFracBits = ddo_pkg::PosFracBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ddo_pkg::ddo_cmd_t    cmd_i,
  output ddo_pkg::ddo_status_t      status_o,
  input  wire logic [15:0]          wheel_base_i,
  input  wire logic signed [31:0]   right_count_i,
  input  wire logic signed [31:0]   left_count_i,
  input  wire logic [23:0]          elapsed_us_i,
  output logic [47:0]               pos_x_o,
  output logic [47:0]               pos_y_o,
  output logic [31:0]               heading_o,
  output logic [31:0]               quat_z_o,
  output logic [31:0]               quat_w_o,
  output logic [47:0]               linear_speed_o,
  output logic [47:0]               turn_rate_o
);
  import ddo_pkg::*;

  localparam int unsigned Rs = 31 - PosFracBits;
  localparam int unsigned StepW = $clog2(CordicSteps + 1);

  logic        started_q;
  logic [31:0] prev_r_q, prev_l_q, in_r_q, in_l_q;
  logic [23:0] el_q;
  logic [47:0] acc_x_q, acc_y_q;
  logic [31:0] acc_h_q;
  logic signed [33:0] sum_q, diff_q;
  logic signed [35:0] cyc_q;
  // square root
  logic [63:0] sq_v_q, sq_r_q;
  logic [5:0]  sq_i_q;
  // cordic
  logic signed [63:0] cx_q, cy_q;
  logic signed [35:0] cz_q;
  logic [StepW-1:0] ci_q;
  logic        flip_q;
  // divider
  logic [67:0] rem_q;
  logic [67:0] quo_q;
  logic [6:0]  di_q;
  logic        dneg_q, which_q;
  logic [23:0] den_q;
  logic [47:0] lin_q, trn_q;
  logic [31:0] qz_q, qw_q;
  logic [31:0] sin_q, cos_q;

  logic signed [34:0] dr_w, dl_w;
  logic [31:0] dr32, dl32;
  logic [33:0] mag_w;
  logic [63:0] bit_w, tst_w;
  logic signed [35:0] cz_x;
  logic signed [63:0] dx_w, dy_w;
  logic [4:0]  ai;
  logic signed [35:0] at_w;
  logic signed [67:0] prod_w;
  logic [67:0] rem_sh;
  logic        qbit_w;
  logic [31:0] ang_w;
  logic signed [31:0] ang_s;

  function automatic logic signed [63:0] clampq(input logic signed [63:0] v);
    return (v > 64'(Q30One)) ? 64'(Q30One) : ((v < -64'(Q30One)) ? -64'(Q30One) : v);
  endfunction

  function automatic logic signed [63:0] rot_x(input logic signed [63:0] x,
      input logic signed [35:0] z, input logic signed [63:0] d);
    return clampq((z >= 0) ? x - d : x + d);
  endfunction

  function automatic logic signed [63:0] rot_y(input logic signed [63:0] y,
      input logic signed [35:0] z, input logic signed [63:0] d);
    return clampq((z >= 0) ? y + d : y - d);
  endfunction

  function automatic logic [47:0] sat48(input logic [66:0] q, input logic b,
      input logic neg);
    logic [68:0] full;
    logic [47:0] mag;
    full = {1'b0, q, b};
    mag = (full > 69'(VelMax)) ? {1'b0, VelMax} : full[47:0];
    return neg ? 48'(-mag) : mag;
  endfunction

  assign dr32 = in_r_q - prev_r_q;
  assign dl32 = in_l_q - prev_l_q;
  assign dr_w = 35'(signed'(dr32));
  assign dl_w = 35'(signed'(dl32));
  assign mag_w = diff_q[33] ? 34'(-diff_q) : 34'(diff_q);
  assign ai = 5'(ci_q);
  assign at_w = atan_entry(ai);
  assign dx_w = cy_q >>> ci_q;
  assign dy_w = cx_q >>> ci_q;
  assign cz_x = (cy_q >= 0) ? cz_q + at_w : cz_q - at_w;
  assign bit_w = 64'd1 << {sq_i_q, 1'b0};
  assign tst_w = sq_r_q + bit_w;
  assign rem_sh = {rem_q[66:0], quo_q[67]};
  assign qbit_w = rem_sh >= 68'(den_q);

  assign status_o.started = started_q;
  assign status_o.saturate = (diff_q == 34'sd0) || (wheel_base_i == 16'd0)
                             || (mag_w >= 34'(wheel_base_i));
  assign status_o.sqrt_last = (sq_i_q == 6'd0);
  assign status_o.cordic_last = (ci_q == StepW'(CordicSteps - 1));
  assign status_o.div_last = (di_q == 7'd0);

  always_comb begin
    ang_w = cmd_i.mid ? acc_h_q + 32'(cyc_q >>> 1)
                      : 32'(signed'(acc_h_q) >>> 1);
    ang_s = signed'(ang_w);
    prod_w = signed'(68'(signed'(sin_q))) * 68'(sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      prev_r_q <= '0;
      prev_l_q <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_h_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (!started_q) begin
          prev_r_q <= right_count_i;
          prev_l_q <= left_count_i;
          started_q <= 1'b1;
        end
      end
      if (cmd_i.delta) begin
        prev_r_q <= in_r_q;
        prev_l_q <= in_l_q;
      end
      if (cmd_i.pos_step) begin
        acc_x_q <= acc_x_q + 48'((signed'(68'(signed'(cos_q))) * 68'(sum_q)
                   + (68'sd1 <<< (Rs - 1))) >>> Rs);
        acc_y_q <= acc_y_q + 48'((prod_w + (68'sd1 <<< (Rs - 1))) >>> Rs);
        acc_h_q <= acc_h_q + 32'(cyc_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_r_q <= right_count_i;
      in_l_q <= left_count_i;
      el_q <= (elapsed_us_i == 24'd0) ? 24'd1 : elapsed_us_i;
    end
    if (cmd_i.delta) begin
      sum_q <= 34'(dr_w + dl_w);
      diff_q <= 34'(dr_w - dl_w);
    end
    if (cmd_i.sqr) begin
      sq_v_q <= {4'd0, (32'(wheel_base_i) * 32'(wheel_base_i))
                 - (32'(mag_w[15:0]) * 32'(mag_w[15:0])), 28'd0};
      sq_r_q <= '0;
      sq_i_q <= 6'd31;
      cyc_q <= (diff_q == 34'sd0) ? 36'sd0 : (diff_q[33] ? -Q30One : Q30One);
    end
    if (cmd_i.sqrt_step) begin
      sq_i_q <= sq_i_q - 6'd1;
      if (sq_v_q >= tst_w) begin
        sq_v_q <= sq_v_q - tst_w;
        sq_r_q <= (sq_r_q >> 1) + bit_w;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
    end
    if (cmd_i.vec_init) begin
      cx_q <= (sq_v_q >= tst_w) ? 64'((sq_r_q >> 1) + bit_w) : 64'(sq_r_q >> 1);
      cy_q <= 64'(diff_q) <<< 14;
      cz_q <= '0;
      ci_q <= '0;
    end
    if (cmd_i.vec_step) begin
      ci_q <= ci_q + StepW'(1);
      cz_q <= cz_x;
      if (cy_q >= 0) begin
        cx_q <= cx_q + dx_w; cy_q <= cy_q - dy_w;
      end else begin
        cx_q <= cx_q - dx_w; cy_q <= cy_q + dy_w;
      end
      if (status_o.cordic_last) begin
        cyc_q <= (cz_x > Q30One) ? Q30One : ((cz_x < -Q30One) ? -Q30One : cz_x);
      end
    end
    if (cmd_i.mid || cmd_i.half) begin
      cx_q <= 64'(GainQ30);
      cy_q <= '0;
      ci_q <= '0;
      if (36'(ang_s) > Q30One || 36'(ang_s) < -Q30One) begin
        cz_q <= 36'(signed'(ang_w + 32'h80000000));
        flip_q <= 1'b1;
      end else begin
        cz_q <= 36'(ang_s);
        flip_q <= 1'b0;
      end
    end
    if (cmd_i.rot_step) begin
      ci_q <= ci_q + StepW'(1);
      if (cz_q >= 0) begin
        cx_q <= cx_q - dx_w; cy_q <= cy_q + dy_w; cz_q <= cz_q - at_w;
      end else begin
        cx_q <= cx_q + dx_w; cy_q <= cy_q - dy_w; cz_q <= cz_q + at_w;
      end
    end
    if (cmd_i.div_step && status_o.div_last) begin
      if (!which_q) lin_q <= sat48(quo_q[66:0], qbit_w, dneg_q);
      else trn_q <= sat48(quo_q[66:0], qbit_w, dneg_q);
    end
    if (cmd_i.div1_init || cmd_i.div2_init) begin
      rem_q <= '0;
      di_q <= 7'd67;
      den_q <= el_q;
      which_q <= cmd_i.div2_init;
      if (cmd_i.div1_init) begin
        dneg_q <= sum_q[33];
        quo_q <= 68'(sum_q[33] ? 34'(-sum_q) : 34'(sum_q)) * 68'd1000000 << 15;
      end else begin
        dneg_q <= cyc_q[35];
        quo_q <= 68'(cyc_q[35] ? 36'(-cyc_q) : 36'(cyc_q)) * 68'd1000000;
      end
    end else if (cmd_i.div_step) begin
      di_q <= di_q - 7'd1;
      if (qbit_w) begin
        rem_q <= rem_sh - 68'(den_q);
        quo_q <= {quo_q[66:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[66:0], 1'b0};
      end
    end
  end

  // Rotation results are captured when each rotation finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rot_step && status_o.cordic_last) begin
      if (!cmd_i.div1_init) begin
        sin_q <= 32'(flip_q ? -rot_y(cy_q, cz_q, dy_w) : rot_y(cy_q, cz_q, dy_w));
        cos_q <= 32'(flip_q ? -rot_x(cx_q, cz_q, dx_w) : rot_x(cx_q, cz_q, dx_w));
      end else begin
        qz_q <= 32'(flip_q ? -rot_y(cy_q, cz_q, dy_w) : rot_y(cy_q, cz_q, dy_w));
        qw_q <= 32'(flip_q ? -rot_x(cx_q, cz_q, dx_w) : rot_x(cx_q, cz_q, dx_w));
      end
    end
  end

  assign pos_x_o = acc_x_q;
  assign pos_y_o = acc_y_q;
  assign heading_o = acc_h_q;
  assign quat_z_o = qz_q;
  assign quat_w_o = qw_q;
  assign linear_speed_o = lin_q;
  assign turn_rate_o = trn_q;

endmodule
`default_nettype wire

>>> hw/rtl/differential_drive_odometry_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Differential drive odometry top level
// Wheel odometry with an APB register port and streaming ports.
// ---------------------------------------------------------------------------
// One item is worked on at a time. With the default of 24 CORDIC steps an
// update holds the input off from acceptance to the next one for a 32-step
// square root, a 24-step vectoring pass, two 24-step rotation passes and
// two 68-step restoring divisions, plus the accept, delta, square,
// midpoint, step, half and output states. When the wheel deltas are equal
// or the heading ratio saturates, the square root and vectoring pass are
// skipped. A finished result waits longer only while the previous result
// is still unread. The first item after reset only latches the counts.
// The result sits in an output register while the next item is accepted.
module differential_drive_odometry_top #(
  parameter int unsigned CordicSteps = ddo_pkg::CordicStepsDef,
  parameter int unsigned PosFracBits = ddo_pkg::PosFracBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // right_count[31:0], left_count[63:32], elapsed_us[87:64]
  input  wire logic [87:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x[47:0], pos_y[95:48], heading[127:96], quat_z[159:128],
  // quat_w[191:160], linear_speed[239:192], turn_rate[287:240]
  output logic [287:0]      m_axis_tdata
);
  import ddo_pkg::*;

  ddo_cmd_t    cmd;
  ddo_status_t status;
  logic        busy, in_fire, out_free;
  logic [15:0] wb_q;
  logic        ov_q;
  logic [47:0] px, py, ls, tr;
  logic [31:0] hd, qz, qw;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, wb_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= WheelBaseReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      wb_q <= pwdata[15:0];
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;

  ddo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_free_i(out_free),
    .status_i(status), .cmd_o(cmd), .busy_o(busy)
  );

  ddo_datapath #(.CordicSteps(CordicSteps), .PosFracBits(PosFracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .wheel_base_i(wb_q),
    .right_count_i(s_axis_tdata[31:0]), .left_count_i(s_axis_tdata[63:32]),
    .elapsed_us_i(s_axis_tdata[87:64]), .pos_x_o(px), .pos_y_o(py),
    .heading_o(hd), .quat_z_o(qz), .quat_w_o(qw), .linear_speed_o(ls),
    .turn_rate_o(tr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd.out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) m_axis_tdata <= {tr, ls, qw, qz, hd, py, px};
  end

  assign m_axis_tvalid = ov_q;

endmodule
`default_nettype wire

>>> verif/differential_drive_odometry_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Differential drive odometry testbench
// Streams encoder transactions into the block under several wheel base
// settings, predicts every pose transaction with a bit-exact fixed-point
// odometry model and checks the output stream field by field, with random
// gaps on the input side and random back-pressure on the output side.
// ---------------------------------------------------------------------------
module differential_drive_odometry_top_tb;

  localparam longint Q30 = 64'sd1073741824;
  localparam longint GAIN = 64'sd652032874;
  localparam longint unsigned VMAX = 64'd140737488355327;
  localparam int CyclesLimit = 3000000;

  typedef struct packed {
    logic [31:0] right;
    logic [31:0] left;
    logic [23:0] elapsed;
  } enc_t;

  typedef struct packed {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [31:0] quat_z;
    logic [31:0] quat_w;
    logic [47:0] linear_speed;
    logic [47:0] turn_rate;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;

  always #1 clk_i = ~clk_i;

  differential_drive_odometry_top u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  longint atan_rom [32] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001, 'h00000000
  };

  // Odometry state mirrored from the block.
  logic [15:0] wheel_base = 16'd500;
  bit odo_started = 0;
  logic [31:0] last_right = '0, last_left = '0;
  logic [47:0] odo_x = '0, odo_y = '0;
  logic [31:0] odo_heading = '0;

  enc_t enc_queue[$];
  pose_t pose_queue[$];
  int errors = 0;
  int poses_seen = 0;
  int cycles = 0;

  function automatic longint sx32(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp30(input longint v);
    if (v > Q30) return Q30;
    if (v < -Q30) return -Q30;
    return v;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint sn,
                                  output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = sx32(ang);
    x = GAIN;
    y = 0;
    flip = 0;
    if (z > Q30 || z < -Q30) begin
      z = sx32(ang + 32'h8000_0000);
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_rom[i];
      end else begin
        x += dx; y -= dy; z += atan_rom[i];
      end
    end
    x = clamp30(x);
    y = clamp30(y);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint turn_angle(input longint diff, input longint base);
    longint mag, x, y, z, dx, dy;
    mag = diff < 0 ? -diff : diff;
    z = 0;
    if (diff == 0) return 0;
    if (base == 0 || mag >= base) return diff > 0 ? Q30 : -Q30;
    x = longint'(int_sqrt(longint'(base * base - mag * mag) << 28));
    y = diff * 16384;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_rom[i];
      end else begin
        x -= dx; y += dy; z -= atan_rom[i];
      end
    end
    return clamp30(z);
  endfunction

  function automatic longint step_len(input longint trig, input longint sum);
    return (trig * sum + (64'sd1 << 14)) >>> 15;
  endfunction

  function automatic logic [47:0] speed(input longint v, input longint unsigned e,
                                        input int frac);
    bit neg;
    longint unsigned num, q, r, res;
    neg = v < 0;
    num = longint'(neg ? -v : v) * 64'd1000000;
    q = num / e;
    r = num % e;
    if (q > (VMAX >> frac)) begin
      res = VMAX;
    end else begin
      res = (q << frac) + ((r << frac) / e);
      if (res > VMAX) res = VMAX;
    end
    return neg ? (48'd0 - res[47:0]) : res[47:0];
  endfunction

  function automatic bit odo_update(input enc_t t, output pose_t p);
    longint dr, dl, sum, diff, turn, sn, cs, qz, qw, half;
    logic [31:0] mid;
    longint unsigned e;
    p = '0;
    if (!odo_started) begin
      last_right = t.right;
      last_left = t.left;
      odo_started = 1;
      return 0;
    end
    dr = sx32(t.right - last_right);
    dl = sx32(t.left - last_left);
    last_right = t.right;
    last_left = t.left;
    sum = dr + dl;
    diff = dr - dl;
    turn = turn_angle(diff, longint'(wheel_base));
    mid = odo_heading + 32'(turn >>> 1);
    sin_cos(mid, sn, cs);
    odo_x = odo_x + 48'(step_len(cs, sum));
    odo_y = odo_y + 48'(step_len(sn, sum));
    odo_heading = odo_heading + 32'(turn);
    half = sx32(odo_heading) >>> 1;
    sin_cos(32'(half), qz, qw);
    e = (t.elapsed == 0) ? 64'd1 : longint'(t.elapsed);
    p.pos_x = odo_x;
    p.pos_y = odo_y;
    p.heading = odo_heading;
    p.quat_z = 32'(qz);
    p.quat_w = 32'(qw);
    p.linear_speed = speed(sum, e, 15);
    p.turn_rate = speed(turn, e, 0);
    return 1;
  endfunction

  task automatic report_mismatch(input string field, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH %s: got %h, expected %h (pose %0d)", field, got, want,
             poses_seen);
    errors++;
  endtask

  bit in_burst = 0, out_burst = 0;

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 63) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  // Input driver.
  int in_gap = 0;
  always @(posedge clk_i) begin
    enc_t t;
    pose_t p;
    bit nxt;
    if (rst_ni) begin
      nxt = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        if (odo_update({s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[87:64]}, p))
          pose_queue.push_back(p);
        nxt = 1'b0;
        in_gap = draw_gap(in_burst);
      end
      if (!nxt) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (enc_queue.size() > 0) begin
          t = enc_queue.pop_front();
          s_axis_tdata <= {t.elapsed, t.left, t.right};
          nxt = 1'b1;
        end
      end
      s_axis_tvalid <= nxt;
    end
  end

  // Output monitor.
  int out_gap = 0;
  always @(posedge clk_i) begin
    pose_t got, want;
    bit nxt;
    cycles++;
    if (cycles > CyclesLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end else if (rst_ni) begin
      nxt = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[287:0];
        got = {got.turn_rate, got.linear_speed, got.quat_w, got.quat_z, got.heading,
               got.pos_y, got.pos_x};
        poses_seen++;
        if (pose_queue.size() == 0) begin
          $display("MISMATCH unexpected pose transaction %0d", poses_seen);
          errors++;
        end else begin
          want = pose_queue.pop_front();
          if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.heading !== want.heading)
            report_mismatch("heading", got.heading, want.heading);
          if (got.quat_z !== want.quat_z)
            report_mismatch("quat_z", got.quat_z, want.quat_z);
          if (got.quat_w !== want.quat_w)
            report_mismatch("quat_w", got.quat_w, want.quat_w);
          if (got.linear_speed !== want.linear_speed)
            report_mismatch("linear_speed", got.linear_speed, want.linear_speed);
          if (got.turn_rate !== want.turn_rate)
            report_mismatch("turn_rate", got.turn_rate, want.turn_rate);
        end
        out_gap = draw_gap(out_burst);
        nxt = (out_gap == 0);
      end else if (!m_axis_tready) begin
        if (out_gap > 0) out_gap--;
        nxt = (out_gap == 0);
      end
      m_axis_tready <= nxt;
    end
  end

  // Stimulus helpers.
  logic [31:0] cur_right = '0, cur_left = '0;

  task automatic push_enc(input logic [31:0] r, input logic [31:0] l,
                          input logic [23:0] e);
    enc_queue.push_back('{right: r, left: l, elapsed: e});
    cur_right = r;
    cur_left = l;
  endtask

  task automatic push_move(input longint dr, input longint dl, input logic [23:0] e);
    push_enc(cur_right + 32'(dr), cur_left + 32'(dl), e);
  endtask

  task automatic drain();
    while (enc_queue.size() > 0 || s_axis_tvalid || pose_queue.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [15:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    wheel_base = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    longint b, dr, dl;
    logic [23:0] e;
    int kind;
    b = longint'(wheel_base);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: e = 24'd1;
        1, 2: e = 24'($urandom_range(1, 24'hFF_FFFF));
        default: e = 24'($urandom_range(1, 200000));
      endcase
      if (kind < 55) begin
        dr = longint'($urandom_range(0, 4000)) - 2000;
        dl = dr + longint'($urandom_range(0, 2 * b)) - b;
        push_move(dr, dl, e);
      end else if (kind < 70) begin
        dr = longint'($urandom_range(0, b)) - b / 2;
        push_move(dr, -dr, e);
      end else if (kind < 82) begin
        dr = longint'($urandom_range(0, 60)) - 30;
        dl = dr + ($urandom_range(0, 1) ? b : -b) + longint'($urandom_range(0, 4)) - 2;
        push_move(dr, dl, e);
      end else if (kind < 92) begin
        push_enc($urandom, $urandom, e);
      end else begin
        dr = longint'($urandom_range(0, 2000000)) - 1000000;
        push_move(dr, dr, e);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset wheel base of 500 mm.
    push_enc(32'd5, 32'd7, 24'd1000);
    push_move(0, 0, 24'd1000);
    push_move(100, 100, 24'd20000);
    push_move(50, -50, 24'd20000);
    push_move(500, 0, 24'd20000);
    push_move(-300, 400, 24'd20000);
    push_move(0, 500, 24'd20000);
    push_move(1, 0, 24'd1);
    push_move(0, -1, 24'hFF_FFFF);
    push_enc(32'h7FFF_FFF0, 32'h7FFF_FFF0, 24'd5000);
    push_enc(32'h8000_0010, 32'h8000_0010, 24'd5000);
    push_enc(32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
    push_enc(32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
    push_enc(32'hFFFF_FFFF, 32'h0000_0000, 24'hFF_FFFF);
    push_enc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1);
    push_move(499, 0, 24'd100);
    push_move(-499, 0, 24'd100);
    for (int i = 0; i < 6; i++) push_move(300, -300, 24'd33333);
    random_phase(300);
    drain();

    write_base(16'd65535);
    push_move(65535, 0, 24'd10);
    push_move(-65535, 0, 24'd10);
    random_phase(300);
    drain();

    write_base(16'd1);
    push_move(1, 0, 24'd10);
    push_move(0, 0, 24'd10);
    random_phase(300);
    drain();

    for (int k = 0; k < 3; k++) begin
      write_base(16'($urandom_range(100, 3000)));
      random_phase(330);
      drain();
    end
    write_base(16'd500);
    random_phase(60);
    drain();

    $display("Checked %0d pose transactions over seven wheel base settings,", poses_seen);
    $display("with random input gaps and output back-pressure; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_ctrl.sv
hw/rtl/ddo_datapath.sv
hw/rtl/differential_drive_odometry_top.sv
verif/differential_drive_odometry_top_tb.sv
